FILE: sv/ascii_pose_frame_parser_top_defines.svh
// Assertion macros shared by the pose frame parser modules.
// Depends on nothing; included by the files that assert.
`ifndef ASCII_POSE_FRAME_PARSER_TOP_DEFINES_SVH
`define ASCII_POSE_FRAME_PARSER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define APF_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define APF_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: sv/apf_pkg.sv
// Package for the ASCII pose frame parser: constants, character classes.
// Depends on nothing.
package apf_pkg;
	localparam int LINE_BYTES_DEF = 128;
	localparam int RING_DEPTH_DEF = 16;
	localparam int MAX_VALS = 6;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	function automatic logic is_gap(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	typedef struct packed {
		logic        neg;
		logic [17:0] ip;
		logic [29:0] frac;
	} num_t;
endpackage

FILE: sv/apf_conv.sv
// Multi-cycle fixed point converter: integer and nine-digit fraction to Q16.16.
// Depends on apf_pkg.
`include "ascii_pose_frame_parser_top_defines.svh"
module apf_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  apf_pkg::num_t     num,
	output logic              done,
	output logic [31:0]       val
);
	// (frac*65536 + 5e8) / 1e9 equals (frac*128 + 976562) / 5^9.
	// Estimate the quotient with one 32x32 reciprocal product, which lands at most
	// one below the true quotient, then correct it with one compare and subtract.
	// Phases: product, estimate, remainder, correct; done follows the last phase.
	localparam logic [20:0] DEN   = 21'd1953125;
	localparam logic [31:0] RECIP = 32'd2305843009;   // floor(2^52 / DEN)
	localparam logic [36:0] HALF  = 37'd976562;
	logic [1:0]  ph_q;
	logic        busy_q;
	logic [36:0] m_q;
	logic [63:0] pr_q;
	logic [16:0] qe_q;
	logic [36:0] rm_q;
	logic [16:0] quo_q;
	logic        neg_q;
	logic [17:0] ip_q;
	logic [34:0] mag;

	assign mag = {1'b0, ip_q, 16'd0} + {18'd0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				ph_q <= '0;
			end else if (busy_q) begin
				if (ph_q == 2'd3) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_q <= {num.frac, 7'd0} + HALF;
			neg_q <= num.neg;
			ip_q <= num.ip;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: pr_q <= {32'd0, m_q[36:5]} * {32'd0, RECIP};
				2'd1: qe_q <= pr_q[63:47];
				2'd2: rm_q <= m_q - {20'd0, qe_q} * {16'd0, DEN};
				default: quo_q <= (rm_q >= {16'd0, DEN}) ? qe_q + 17'd1 : qe_q;
			endcase
		end
	end

	always_comb begin
		if (neg_q) val = (mag > 35'h80000000) ? 32'h80000000 : 32'd0 - mag[31:0];
		else val = (mag > 35'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
	end

	`APF_ASSERT_NXT(a_go_busy, clk, arst_n, go, busy_q, "converter did not start")
	`APF_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy_q, "done while busy")
	`APF_ASSERT_IMP(a_quo_narrow, clk, arst_n, done, quo_q <= 17'd65536, "fraction overflow")
endmodule

FILE: sv/ascii_pose_frame_parser_top.sv
// Top level of the ASCII pose frame parser: line store, frame sequencer, rings.
// Depends on apf_pkg, apf_conv and the assertion header.
//
//  channel  | handshake          | payload
//  input    | start / busy       | rx_byte
//  result   | strobe (one cycle) | pose_kind .. update_seq
//
// A byte that does not end a frame is stored while idle. A frame end runs a scan
// with one store read per cycle: blank check, normalize, then the marker search.
// The parser then consumes the bytes and converts each value (fraction padding,
// then the shared converter).
// arst_n clears control and ring bookkeeping; stores are not cleared.
// The receiver cannot stall: strobe lasts one cycle.
`include "ascii_pose_frame_parser_top_defines.svh"
module ascii_pose_frame_parser_top #(
	parameter int LINE_BYTES = apf_pkg::LINE_BYTES_DEF,
	parameter int RING_DEPTH = apf_pkg::RING_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        rx_byte,
	output logic              strobe,
	output logic              pose_kind,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] ang_roll,
	output logic signed [31:0] ang_pitch,
	output logic signed [31:0] ang_yaw,
	output logic              has_rpy,
	output logic [3:0]        ring_slot,
	output logic [4:0]        ring_fill,
	output logic [31:0]       update_seq
);
	localparam int AW = $clog2(LINE_BYTES);
	localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam logic [AW:0] LAST = (AW+1)'(LINE_BYTES - 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_BLANK = 4'd1, ST_NORM = 4'd2,
		ST_FIND = 4'd3, ST_SKIP = 4'd4, ST_SIGN = 4'd5, ST_NUM = 4'd6,
		ST_CONV = 4'd7, ST_WAIT = 4'd8, ST_SEP = 4'd9, ST_EMIT = 4'd10,
		ST_RD = 4'd11;

	logic [3:0]   state_q, ret_q;
	logic [7:0]   line_mem [LINE_BYTES];
	logic [7:0]   norm_mem [LINE_BYTES];
	logic [AW:0]  pos_q;           // line fill
	logic [7:0]   tail_q [2];      // last two stored bytes
	logic [AW:0]  rp_q, n_q, s_q, e_q, h_q, t_q;
	logic         hf_q, tf_q;
	logic [7:0]   rd_q, win0_q, win1_q;
	logic [7:0]   nrd_q;
	logic [2:0]   cnt_q;
	logic [31:0]  vals_q [apf_pkg::MAX_VALS];
	apf_pkg::num_t num_q;
	logic [3:0]   fd_q;
	logic         nd_q, in_frac_q, sign_ok_q;
	logic         conv_go, conv_done;
	logic [31:0]  conv_val;
	logic [RW-1:0] dwi_q, twi_q;
	logic [FW-1:0] dfill_q, tfill_q;
	logic [31:0]  dseq_q, tseq_q;
	logic [7:0]   c_nx;
	logic [AW:0]  npos;
	logic         ends;
	logic [20:0]  ip_nx;

	assign busy = (state_q != ST_IDLE);
	assign npos = pos_q + 1'b1;
	assign ends = (rx_byte == apf_pkg::CH_LF) || (npos >= LAST) ||
		(npos >= 3 && tail_q[1] == 8'h2C && tail_q[0] == 8'h42 && rx_byte == 8'h42);
	assign c_nx = nrd_q;
	assign ip_nx = {3'b0, num_q.ip} * 21'd10 + {17'd0, c_nx[3:0]};

	// Line store write and read.
	always_ff @(posedge clk) begin
		if (start && !busy && rx_byte != 8'd0 &&
			!(pos_q == 0 && (rx_byte == apf_pkg::CH_LF || rx_byte == apf_pkg::CH_CR)) &&
			pos_q < LAST)
			line_mem[pos_q[AW-1:0]] <= rx_byte;
		rd_q <= line_mem[rp_q[AW-1:0]];
	end

	// Normalized store: written in the normalize pass, read in the parse passes.
	always_ff @(posedge clk) begin
		if (state_q == ST_NORM && rp_q > 0 && !apf_pkg::is_gap(rd_q))
			norm_mem[n_q[AW-1:0]] <= apf_pkg::to_upper(rd_q);
		nrd_q <= norm_mem[rp_q[AW-1:0]];
	end

	apf_conv u_conv (.clk(clk), .arst_n(arst_n), .go(conv_go), .num(num_q),
		.done(conv_done), .val(conv_val));

	assign conv_go = (state_q == ST_CONV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; pos_q <= '0; strobe <= 1'b0;
			dwi_q <= '0; dfill_q <= '0; dseq_q <= '0;
			twi_q <= '0; tfill_q <= '0; tseq_q <= '0;
			tail_q[0] <= '0; tail_q[1] <= '0;
			ret_q <= ST_IDLE; rp_q <= '0; cnt_q <= '0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && rx_byte != 8'd0 &&
						!(pos_q == 0 && (rx_byte == apf_pkg::CH_LF ||
						rx_byte == apf_pkg::CH_CR))) begin
						// Store the byte; on frame end start the blank scan.
						pos_q <= npos;
						tail_q[1] <= tail_q[0];
						tail_q[0] <= rx_byte;
						if (ends) begin
							state_q <= ST_BLANK;
							rp_q <= '0;
						end
					end
				end
				ST_BLANK: begin
					// rd_q is a registered read: it holds the byte at the rp_q of the cycle before.
					if (rp_q > 0 && !apf_pkg::is_blank(rd_q)) begin
						state_q <= ST_NORM; rp_q <= '0; n_q <= '0;
					end else if (rp_q == pos_q) begin
						state_q <= ST_IDLE; pos_q <= '0;
					end else rp_q <= rp_q + 1'b1;
				end
				ST_NORM: begin
					if (rp_q > 0 && !apf_pkg::is_gap(rd_q)) n_q <= n_q + 1'b1;
					if (rp_q == pos_q) begin
						state_q <= ST_FIND; rp_q <= '0; hf_q <= 1'b0; tf_q <= 1'b0;
						win0_q <= '0; win1_q <= '0;
					end else rp_q <= rp_q + 1'b1;
				end
				ST_FIND: begin
					// Slide a three-byte window over the normalized text; decide in the
					// cycle after the last byte so a marker at the very end counts.
					if (rp_q > 0 && rp_q <= n_q) begin
						win1_q <= win0_q; win0_q <= nrd_q;
						if (rp_q >= 3 && !hf_q && win1_q == 8'h41 && win0_q == 8'h41 &&
							nrd_q == 8'h2C) begin
							hf_q <= 1'b1; h_q <= rp_q - 3'd3;
						end
						if (rp_q >= 3 && !tf_q && win1_q == 8'h2C && win0_q == 8'h42 &&
							nrd_q == 8'h42) begin
							tf_q <= 1'b1; t_q <= rp_q - 3'd3;
						end
					end
					if (rp_q > n_q) begin
						if (hf_q && tf_q && t_q > h_q) begin
							s_q <= h_q + 3'd3; e_q <= t_q;
						end else begin
							s_q <= '0; e_q <= n_q;
						end
						state_q <= ST_SKIP; cnt_q <= '0;
					end else rp_q <= rp_q + 1'b1;
				end
				ST_SKIP: begin
					// Begin a number at s_q, or emit once the span or the value count is used up.
					if (s_q >= e_q || cnt_q == 3'(apf_pkg::MAX_VALS)) state_q <= ST_EMIT;
					else begin
						rp_q <= s_q; ret_q <= ST_SIGN; state_q <= ST_RD;
						num_q <= '0; fd_q <= '0; nd_q <= 1'b0; in_frac_q <= 1'b0;
						sign_ok_q <= 1'b1;
					end
				end
				ST_RD: state_q <= ret_q;    // wait for the registered read port
				ST_SIGN: begin
					if (rp_q < e_q && (c_nx == 8'd11 || c_nx == 8'd12) && sign_ok_q) begin
						rp_q <= rp_q + 1'b1; state_q <= ST_RD;
					end else begin
						sign_ok_q <= 1'b0;
						if (rp_q < e_q && (c_nx == 8'h2B || c_nx == 8'h2D)) begin
							num_q.neg <= (c_nx == 8'h2D);
							rp_q <= rp_q + 1'b1; ret_q <= ST_NUM; state_q <= ST_RD;
						end else state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (rp_q < e_q && apf_pkg::is_digit(c_nx)) begin
						nd_q <= 1'b1;
						if (!in_frac_q)
							num_q.ip <= (ip_nx > 21'h20000) ? 18'h20000 : ip_nx[17:0];
						else if (fd_q < 4'd9) begin
							num_q.frac <= num_q.frac * 30'd10 + {26'd0, c_nx[3:0]};
							fd_q <= fd_q + 1'b1;
						end
						rp_q <= rp_q + 1'b1; ret_q <= ST_NUM; state_q <= ST_RD;
					end else if (rp_q < e_q && c_nx == 8'h2E && !in_frac_q) begin
						in_frac_q <= 1'b1;
						rp_q <= rp_q + 1'b1; ret_q <= ST_NUM; state_q <= ST_RD;
					end else if (!nd_q) state_q <= ST_EMIT;
					else if (fd_q < 4'd9) begin
						num_q.frac <= num_q.frac * 30'd10; fd_q <= fd_q + 1'b1;
					end else state_q <= ST_CONV;
				end
				ST_CONV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (conv_done) begin
						vals_q[cnt_q] <= conv_val; cnt_q <= cnt_q + 1'b1;
						state_q <= ST_SEP;
					end
				end
				ST_SEP: begin
					if (rp_q < e_q && c_nx == 8'h2C) begin
						s_q <= rp_q + 1'b1; state_q <= ST_SKIP;
					end else state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// With four or six values, publish a pose and advance the matching ring bookkeeping.
					state_q <= ST_IDLE; pos_q <= '0;
					if (cnt_q == 3'd4) begin
						strobe <= 1'b1; pose_kind <= 1'b0; has_rpy <= 1'b0;
						ang_pitch <= '0; ang_roll <= vals_q[3]; ang_yaw <= vals_q[3];
						ring_slot <= 4'(dwi_q);
						dwi_q <= (dwi_q == RW'(RING_DEPTH - 1)) ? '0 : dwi_q + 1'b1;
						if (dfill_q < FW'(RING_DEPTH)) begin
							dfill_q <= dfill_q + 1'b1; ring_fill <= 5'(dfill_q + 1'b1);
						end else ring_fill <= 5'(dfill_q);
						dseq_q <= dseq_q + 1'b1; update_seq <= dseq_q + 1'b1;
					end else if (cnt_q == 3'd6) begin
						strobe <= 1'b1; pose_kind <= 1'b1; has_rpy <= 1'b1;
						ang_roll <= vals_q[3]; ang_pitch <= vals_q[4]; ang_yaw <= vals_q[5];
						ring_slot <= 4'(twi_q);
						twi_q <= (twi_q == RW'(RING_DEPTH - 1)) ? '0 : twi_q + 1'b1;
						if (tfill_q < FW'(RING_DEPTH)) begin
							tfill_q <= tfill_q + 1'b1; ring_fill <= 5'(tfill_q + 1'b1);
						end else ring_fill <= 5'(tfill_q);
						tseq_q <= tseq_q + 1'b1; update_seq <= tseq_q + 1'b1;
					end
					pos_x <= vals_q[0]; pos_y <= vals_q[1]; pos_z <= vals_q[2];
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`APF_ASSERT_IMP(a_strobe_idle, clk, arst_n, strobe, state_q == ST_IDLE, "strobe outside idle")
	`APF_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= 3'd6, "value count overflow")
	`APF_ASSERT_NXT(a_start_ack, clk, arst_n, start && !busy && ends && rx_byte != 8'd0 && pos_q != 0, busy, "frame end not taken")
	`APF_ASSERT_IMP(a_pos_bound, clk, arst_n, 1'b1, pos_q <= LAST, "line overflow")
endmodule
